// ----- hdl/assert_macros.svh -----
// assertion macros shared by the solver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define DVPS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// implication checked at every clock edge out of reset
`define DVPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define DVPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/dvps_pkg.sv -----
// types and constants of the dual variable piecewise solver
`default_nettype none
package dvps_pkg;

  localparam int MAX_TERMS = 64;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  localparam logic [51:0] TERM_CAP = {52{1'b1}};
  localparam logic [90:0] ROOT_LIM = 91'(1) << 62;

  localparam int DIV_NW = 90;
  localparam int DIV_DW = 64;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOPE_MUL,
    S_SLOPE_START,
    S_SLOPE_DIV,
    S_MUL_LO,
    S_MUL_HI,
    S_ICPT,
    S_INS_RD,
    S_INS_CMP,
    S_SOLVE,
    S_SCAN_RD,
    S_SCAN_START,
    S_SCAN_WAIT,
    S_SCAN_CMP,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    OUT_ROOT     = 2'd0,
    OUT_FALLBACK = 2'd1,
    OUT_CLAMPED  = 2'd2
  } outcome_e;

  typedef struct packed {
    logic signed [47:0] bp;
    logic signed [63:0] icpt;
    logic        [63:0] slope;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
    logic              rem_nz;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/dvps_div.sv -----
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module dvps_div (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  dvps_pkg::div_req_t req_i,
  output dvps_pkg::div_rsp_t rsp_o
);

  localparam int NW = dvps_pkg::DIV_NW;
  localparam int DW = dvps_pkg::DIV_DW;
  localparam int CW = dvps_pkg::DIV_CW;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   shifted;
  logic          ge;

  always_comb begin
    shifted = {rem_q, quo_q[NW-1]};
    ge      = shifted >= {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      // shift in the next numerator bit, quotient bits fill from the bottom
      quo_d = {quo_q[NW-2:0], ge};
      rem_d = ge ? DW'(shifted - {1'b0, den_q}) : DW'(shifted);
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quo    = quo_q;
  assign rsp_o.rem_nz = |rem_q;

endmodule
`default_nettype wire

// ----- hdl/dual_variable_piecewise_solver_core.sv -----
// top level of the dual variable piecewise solver: term store, insertion sort and root scan
// each term: slope multiply and divide, low and high intercept multiplies, then an insertion pass
// shifting larger entries up; last term adds a scan of up to term_count entries (90-step divides)
// throughput: one item at a time; the serial divider and the one-read one-write term memory set it
// output result is held in a register, the next run starts once it is loaded
// reset: asynchronous active low, clears count and sums; the term memory is not cleared
`default_nettype none
`include "assert_macros.svh"
module dual_variable_piecewise_solver_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  // input terms
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // share_theta, weight_v, neighbour_dual, supply_count, demand_budget, demand_penalty, node_tag
  input  wire  [207:0] s_axis_tdata,
  // solve_alpha
  input  wire          s_axis_tuser,
  // last_term
  input  wire          s_axis_tlast,
  // results
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // dual_value, outcome, result_tag, zero pad
  output logic [55:0]  m_axis_tdata
);

  localparam int AW = dvps_pkg::ADDR_W;
  localparam int CW = dvps_pkg::CNT_W;

  dvps_pkg::state_e state_q, state_d;

  // latched term fields
  logic               alpha_q, last_q;
  logic [31:0]        theta_q, v_q;
  logic [23:0]        s_q;
  logic [39:0]        budget_q;
  logic signed [31:0] pen_q;
  logic [15:0]        tag_q;
  logic signed [33:0] bp_q;
  logic [32:0]        mag_q;

  // per-term datapath
  logic [55:0]        ms_q;
  logic [51:0]        slope_q;
  logic [58:0]        plo_q, phi_q;
  logic signed [63:0] icpt_q;

  // store bookkeeping
  logic [CW-1:0]      count_q, k_q, i_q;
  logic signed [63:0] isum_q, arun_q;
  logic [63:0]        ssum_q, brun_q;
  logic signed [63:0] x_q;
  logic               neg_q, found_q;

  // output register
  logic               ovalid_q;
  logic [31:0]        oval_q;
  logic [1:0]         ooutc_q;
  logic [15:0]        otag_q;

  // term memory
  dvps_pkg::entry_t   mem [dvps_pkg::MAX_TERMS];
  dvps_pkg::entry_t   rdata_q, wdata;
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;

  dvps_pkg::div_req_t div_req;
  dvps_pkg::div_rsp_t div_rsp;

  dvps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // input decode
  logic               accept, ignore, in_alpha;
  logic [31:0]        in_theta, in_v;
  logic signed [31:0] in_dual;
  logic [23:0]        in_s;
  logic signed [33:0] in_bp;

  assign in_alpha = s_axis_tuser;
  assign in_theta = s_axis_tdata[31:0];
  assign in_v     = s_axis_tdata[63:32];
  assign in_dual  = s_axis_tdata[95:64];
  assign in_s     = s_axis_tdata[119:96];
  assign in_bp    = in_alpha ? ($signed({2'b00, in_v}) - 34'(in_dual))
                             : ($signed({2'b00, in_v}) + 34'(in_dual));
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign ignore   = (in_theta == '0) || (in_v == '0) || (in_alpha && (in_s == '0)) ||
                    (count_q >= CW'(dvps_pkg::MAX_TERMS));

  // intercept from the two partial products
  logic [84:0] prod;
  logic [63:0] val;
  always_comb begin
    prod = 85'(plo_q) + (85'(phi_q) << 26);
    val  = (|prod[84:80]) ? 64'(dvps_pkg::TERM_CAP) : prod[79:16];
    if (bp_q < 0 && (|prod[15:0]) && val < 64'(dvps_pkg::TERM_CAP)) val = val + 64'd1;
    if (val > 64'(dvps_pkg::TERM_CAP)) val = 64'(dvps_pkg::TERM_CAP);
  end

  // root numerator a*2^16 - y*2^48, as sign and magnitude
  logic [39:0]        yval;
  logic signed [90:0] numer;
  logic               nneg;
  logic [90:0]        nmag;
  always_comb begin
    yval  = alpha_q ? budget_q : 40'd1;
    numer = (91'(arun_q) <<< 16) - $signed(91'(yval) << 48);
    nneg  = numer[90];
    nmag  = nneg ? 91'(-numer) : 91'(numer);
  end

  // root from divider result, floored and limited
  logic [90:0]        qadj, rmag;
  logic signed [63:0] xroot;
  always_comb begin
    qadj  = 91'(div_rsp.quo) + 91'(neg_q && div_rsp.rem_nz);
    rmag  = (qadj > dvps_pkg::ROOT_LIM) ? dvps_pkg::ROOT_LIM : qadj;
    xroot = neg_q ? -$signed(64'(rmag)) : $signed(64'(rmag));
  end

  // final result
  logic signed [64:0] nx;
  logic [31:0]        rval;
  dvps_pkg::outcome_e routc;
  always_comb begin
    nx = -65'(x_q);
    if (alpha_q) begin
      if (!found_q) begin
        rval = pen_q;  routc = dvps_pkg::OUT_FALLBACK;
      end else if (nx > 65'(pen_q)) begin
        rval = pen_q;  routc = dvps_pkg::OUT_CLAMPED;
      end else if (nx < -65'sd2147483648) begin
        rval = 32'h8000_0000;  routc = dvps_pkg::OUT_CLAMPED;
      end else begin
        rval = nx[31:0];  routc = dvps_pkg::OUT_ROOT;
      end
    end else begin
      if (!found_q) begin
        rval = '0;  routc = dvps_pkg::OUT_FALLBACK;
      end else if (x_q < 0) begin
        rval = '0;  routc = dvps_pkg::OUT_CLAMPED;
      end else if (x_q > 64'sd2147483647) begin
        rval = 32'h7fff_ffff;  routc = dvps_pkg::OUT_CLAMPED;
      end else begin
        rval = x_q[31:0];  routc = dvps_pkg::OUT_ROOT;
      end
    end
  end

  logic out_load;
  assign out_load = (state_q == dvps_pkg::S_OUT) && (!ovalid_q || m_axis_tready);

  logic bp_gt, x_le;
  assign bp_gt = rdata_q.bp > 48'(bp_q);
  assign x_le  = x_q <= 64'(rdata_q.bp);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dvps_pkg::S_IDLE:        if (accept) begin
        if (!ignore)           state_d = dvps_pkg::S_SLOPE_MUL;
        else if (s_axis_tlast) state_d = dvps_pkg::S_SOLVE;
      end
      dvps_pkg::S_SLOPE_MUL:   state_d = dvps_pkg::S_SLOPE_START;
      dvps_pkg::S_SLOPE_START: state_d = dvps_pkg::S_SLOPE_DIV;
      dvps_pkg::S_SLOPE_DIV:   if (div_rsp.done) state_d = dvps_pkg::S_MUL_LO;
      dvps_pkg::S_MUL_LO:      state_d = dvps_pkg::S_MUL_HI;
      dvps_pkg::S_MUL_HI:      state_d = dvps_pkg::S_ICPT;
      dvps_pkg::S_ICPT:        state_d = dvps_pkg::S_INS_RD;
      dvps_pkg::S_INS_RD:      begin
        if (k_q != '0)  state_d = dvps_pkg::S_INS_CMP;
        else if (last_q) state_d = dvps_pkg::S_SOLVE;
        else             state_d = dvps_pkg::S_IDLE;
      end
      dvps_pkg::S_INS_CMP:     begin
        if (bp_gt)       state_d = dvps_pkg::S_INS_RD;
        else if (last_q) state_d = dvps_pkg::S_SOLVE;
        else             state_d = dvps_pkg::S_IDLE;
      end
      dvps_pkg::S_SOLVE:       state_d = dvps_pkg::S_SCAN_RD;
      dvps_pkg::S_SCAN_RD:     state_d = (i_q == count_q) ? dvps_pkg::S_OUT
                                                          : dvps_pkg::S_SCAN_START;
      dvps_pkg::S_SCAN_START:  state_d = dvps_pkg::S_SCAN_WAIT;
      dvps_pkg::S_SCAN_WAIT:   if (div_rsp.done) state_d = dvps_pkg::S_SCAN_CMP;
      dvps_pkg::S_SCAN_CMP:    state_d = x_le ? dvps_pkg::S_OUT : dvps_pkg::S_SCAN_RD;
      dvps_pkg::S_OUT:         if (out_load) state_d = dvps_pkg::S_IDLE;
      default:                 state_d = dvps_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state_q == dvps_pkg::S_IDLE);
    we            = 1'b0;
    waddr         = k_q[AW-1:0];
    wdata         = rdata_q;
    re            = 1'b0;
    raddr         = AW'(k_q - CW'(1));
    div_req.start = 1'b0;
    div_req.num   = {2'b00, ms_q, 32'd0};
    div_req.den   = {32'd0, v_q};
    case (state_q)
      dvps_pkg::S_SLOPE_START: div_req.start = 1'b1;
      dvps_pkg::S_INS_RD:      begin
        if (k_q != '0) re = 1'b1;
        else begin
          // new term goes to the bottom slot
          we    = 1'b1;
          wdata = '{bp: 48'(bp_q), icpt: icpt_q, slope: 64'(slope_q)};
        end
      end
      dvps_pkg::S_INS_CMP:     begin
        we = 1'b1;
        if (!bp_gt) wdata = '{bp: 48'(bp_q), icpt: icpt_q, slope: 64'(slope_q)};
      end
      dvps_pkg::S_SCAN_RD:     begin
        re    = (i_q != count_q);
        raddr = i_q[AW-1:0];
      end
      dvps_pkg::S_SCAN_START:  begin
        div_req.start = 1'b1;
        div_req.num   = nmag[89:0];
        div_req.den   = brun_q;
      end
      default: ;
    endcase
  end

  // term memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dvps_pkg::S_IDLE;
      count_q  <= '0;
      isum_q   <= '0;
      ssum_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == dvps_pkg::S_INS_RD && k_q == '0) ||
          (state_q == dvps_pkg::S_INS_CMP && !bp_gt)) begin
        count_q <= count_q + CW'(1);
        isum_q  <= isum_q + icpt_q;
        ssum_q  <= ssum_q + 64'(slope_q);
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
        count_q  <= '0;
        isum_q   <= '0;
        ssum_q   <= '0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      dvps_pkg::S_IDLE:      if (accept) begin
        alpha_q  <= in_alpha;
        last_q   <= s_axis_tlast;
        theta_q  <= in_theta;
        v_q      <= in_v;
        s_q      <= in_s;
        budget_q <= s_axis_tdata[159:120];
        pen_q    <= s_axis_tdata[191:160];
        tag_q    <= s_axis_tdata[207:192];
        bp_q     <= in_bp;
        mag_q    <= in_bp[33] ? 33'(-in_bp) : 33'(in_bp);
        k_q      <= count_q;
      end
      dvps_pkg::S_SLOPE_MUL: ms_q <= (alpha_q ? s_q : 24'd1) * theta_q;
      dvps_pkg::S_SLOPE_DIV: if (div_rsp.done) begin
        slope_q <= (|div_rsp.quo[89:52]) ? dvps_pkg::TERM_CAP : div_rsp.quo[51:0];
      end
      dvps_pkg::S_MUL_LO:    plo_q <= slope_q[25:0] * mag_q;
      dvps_pkg::S_MUL_HI:    phi_q <= slope_q[51:26] * mag_q;
      dvps_pkg::S_ICPT:      icpt_q <= bp_q[33] ? -$signed(val) : $signed(val);
      dvps_pkg::S_INS_CMP:   if (bp_gt) k_q <= k_q - CW'(1);
      dvps_pkg::S_SOLVE:     begin
        arun_q <= isum_q;
        brun_q <= ssum_q;
        i_q    <= '0;
      end
      dvps_pkg::S_SCAN_RD:   if (i_q == count_q) found_q <= 1'b0;
      dvps_pkg::S_SCAN_START: neg_q <= nneg;
      dvps_pkg::S_SCAN_WAIT: if (div_rsp.done) x_q <= xroot;
      dvps_pkg::S_SCAN_CMP:  begin
        if (x_le) found_q <= 1'b1;
        else begin
          // drop this entry from the suffix
          arun_q <= arun_q - rdata_q.icpt;
          brun_q <= brun_q - rdata_q.slope;
          i_q    <= i_q + CW'(1);
        end
      end
      dvps_pkg::S_OUT:       if (out_load) begin
        oval_q  <= rval;
        ooutc_q <= routc;
        otag_q  <= tag_q;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, otag_q, ooutc_q, oval_q};

  `DVPS_ASSERT_ALWAYS(a_count_range, count_q <= CW'(dvps_pkg::MAX_TERMS))
  `DVPS_ASSERT_IMPL(a_done_when_waiting, div_rsp.done,
                    state_q == dvps_pkg::S_SLOPE_DIV || state_q == dvps_pkg::S_SCAN_WAIT)
  `DVPS_ASSERT_IMPL(a_scan_index, state_q == dvps_pkg::S_SCAN_RD, i_q <= count_q)
  `DVPS_ASSERT_NEXT(a_load_clears, out_load, count_q == '0 && ovalid_q)

endmodule
`default_nettype wire
